@@ src/jdz_pkg.sv @@
// ----------------------------------------------------------------------------
// Joystick conditioner package
// Shared widths, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package jdz_pkg;

	localparam int AngleSteps = 16;
	localparam int StepW = 5;
	localparam int CordW = 26;

	typedef enum logic [2:0] {
		REG_CTYPE     = 3'd0,
		REG_MOVE_DZ   = 3'd1,
		REG_AIM_DZ    = 3'd2,
		REG_MOVE_GAIN = 3'd3,
		REG_AIM_GAIN  = 3'd4,
		REG_AIM_TH    = 3'd5,
		REG_FIRE_TH   = 3'd6,
		REG_SPARE     = 3'd7
	} reg_idx_t;

	localparam logic [1:0] CTYPE_XBOX = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_LANE = 2'd1,
		ST_ROT  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	// Rotation angles of the vectoring steps, atan(2^-i) in units of pi/32768.
	function automatic logic [15:0] atan_lut(input logic [StepW-1:0] i);
		case (i)
			5'd0: atan_lut = 16'd8192;
			5'd1: atan_lut = 16'd4836;
			5'd2: atan_lut = 16'd2555;
			5'd3: atan_lut = 16'd1297;
			5'd4: atan_lut = 16'd651;
			5'd5: atan_lut = 16'd326;
			5'd6: atan_lut = 16'd163;
			5'd7: atan_lut = 16'd81;
			5'd8: atan_lut = 16'd41;
			5'd9: atan_lut = 16'd20;
			5'd10: atan_lut = 16'd10;
			5'd11: atan_lut = 16'd5;
			5'd12: atan_lut = 16'd3;
			5'd13: atan_lut = 16'd1;
			5'd14: atan_lut = 16'd1;
			default: atan_lut = 16'd0;
		endcase
	endfunction

endpackage

@@ src/jdz_lane.sv @@
// ----------------------------------------------------------------------------
// Dead-zone lane
// Removes the dead zone from one axis and rescales it, one register stage.
// ----------------------------------------------------------------------------
module jdz_lane import jdz_pkg::*; (
	input  logic               clk,
	input  logic signed [15:0] axis,
	input  logic        [14:0] dz,
	input  logic        [15:0] gain,
	output logic signed [15:0] ctl
);

	logic        [15:0] mag;
	logic        [16:0] excess;
	logic        [32:0] prod;
	logic        [17:0] rnd;
	logic        [14:0] sat;
	logic               neg;

	always_comb begin
		neg = axis[15];
		mag = neg ? 16'(-axis) : axis;
		excess = {1'b0, mag} - {2'b00, dz};
		prod = 33'(excess[15:0]) * 33'(gain) + 33'd16384;
		rnd = prod[32:15];
		sat = (rnd > 18'd32767) ? 15'h7fff : rnd[14:0];
	end

	always_ff @(posedge clk) begin
		if ({1'b0, mag} > {2'b00, dz}) begin
			ctl <= neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		end else begin
			ctl <= '0;
		end
	end

endmodule

@@ src/jdz_cordic.sv @@
// ----------------------------------------------------------------------------
// Aim angle CORDIC
// Vectoring-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module jdz_cordic import jdz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	output logic               done,
	output logic        [15:0] angle
);

	logic signed [CordW-1:0] x_q, y_q;
	logic        [15:0]      z_q;
	logic        [StepW-1:0] step_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [CordW-1:0] xs, ys, x0, y0;

	always_comb begin
		x0 = CordW'(x_in) <<< 8;
		y0 = CordW'(y_in) <<< 8;
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			// Raised once the last rotation has landed in z_q.
			done_q <= !start && busy_q && (step_q == StepW'(AngleSteps - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(AngleSteps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in[15] ? -x0 : x0;
			y_q <= x_in[15] ? -y0 : y0;
			z_q <= x_in[15] ? 16'h8000 : 16'h0000;
		end else if (busy_q) begin
			if (!y_q[CordW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(step_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(step_q);
			end
		end
	end

	assign done = done_q;
	assign angle = z_q;

endmodule

@@ src/joystick_dead_zone_conditioner.sv @@
// ----------------------------------------------------------------------------
// Joystick dead-zone conditioner
// Four dead-zone lanes, aim length test, CORDIC angle and button edges.
// ----------------------------------------------------------------------------
// A sample with read_ok set passes through the LANE and OUT states when the aim
// stick is below its threshold, and through LANE, ROT and OUT when the angle is
// updated by the 16-step CORDIC that rotates once per cycle; one sample is in work
// at a time. Samples with read_ok clear are dropped and change nothing. The result
// sits in an output register, and the next sample is taken once it is placed there.
module joystick_dead_zone_conditioner import jdz_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// read_ok[0], axis_0..axis_6 [112:1], raw_buttons [124:113], zero pad
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// move_left[14:0], move_right[29:15], move_up[44:30], move_down[59:45],
	// aim_angle[75:60], fire[76], buttons[88:77], pressed[100:89],
	// released[112:101], zero pad
	output logic [119:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [1:0]  ctype_q;
	logic [14:0] move_dz_q, aim_dz_q;
	logic [15:0] move_gain_q, aim_gain_q, aim_th_q, fire_th_q;
	logic [11:0] last_btn_q, btn_s1;
	logic [15:0] angle_q;
	state_t      state_q, state_d;
	logic        m_valid_q;
	logic [119:0] m_data_q;

	logic signed [15:0] ax [7];
	logic signed [15:0] aim_x, aim_y;
	logic signed [15:0] c0, c1, c2, c3;
	logic [11:0] raw, btn;
	logic [31:0] len2;
	logic        aim_hit, fire_hit, take, cord_done, fire_q;
	logic [15:0] cord_angle;

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			ax[k] = s_tdata[1 + 16*k +: 16];
		end
		raw = s_tdata[124:113];
		unique case (ctype_q)
			2'd0: begin aim_x = ax[5]; aim_y = ax[6]; end
			2'd1: begin aim_x = ax[5]; aim_y = ax[2]; end
			2'd2: begin aim_x = ax[2]; aim_y = ax[5]; end
			default: begin aim_x = ax[3]; aim_y = ax[4]; end
		endcase
		if (ctype_q == CTYPE_XBOX) begin
			btn = {4'b0, raw[11], raw[10], raw[4], raw[1], raw[3], raw[5], raw[0], raw[2]};
		end else begin
			btn = raw;
		end
	end

	assign take = s_tvalid && s_tready && s_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctype_q <= '0;
			move_dz_q <= 15'd8192;
			aim_dz_q <= 15'd1024;
			move_gain_q <= 16'd43691;
			aim_gain_q <= 16'd33825;
			aim_th_q <= 16'd9830;
			fire_th_q <= 16'd16384;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CTYPE:     ctype_q <= cfg_data[1:0];
				REG_MOVE_DZ:   move_dz_q <= cfg_data[14:0];
				REG_AIM_DZ:    aim_dz_q <= cfg_data[14:0];
				REG_MOVE_GAIN: move_gain_q <= cfg_data;
				REG_AIM_GAIN:  aim_gain_q <= cfg_data;
				REG_AIM_TH:    aim_th_q <= cfg_data;
				REG_FIRE_TH:   fire_th_q <= cfg_data;
				default: ;
			endcase
		end
	end

	jdz_lane u_lane0 (.clk, .axis(ax[0]), .dz(move_dz_q), .gain(move_gain_q), .ctl(c0));
	jdz_lane u_lane1 (.clk, .axis(ax[1]), .dz(move_dz_q), .gain(move_gain_q), .ctl(c1));
	jdz_lane u_lane2 (.clk, .axis(aim_x), .dz(aim_dz_q), .gain(aim_gain_q), .ctl(c2));
	jdz_lane u_lane3 (.clk, .axis(aim_y), .dz(aim_dz_q), .gain(aim_gain_q), .ctl(c3));

	always_ff @(posedge clk) begin
		if (take) begin
			btn_s1 <= btn;
		end
	end

	// Merge stage: squared aim length against both thresholds.
	assign len2 = 32'(c2) * 32'(c2) + 32'(c3) * 32'(c3);
	assign aim_hit = len2 > 32'(aim_th_q) * 32'(aim_th_q);
	assign fire_hit = len2 > 32'(fire_th_q) * 32'(fire_th_q);

	jdz_cordic u_cordic (
		.clk, .arst_n,
		.start(state_q == ST_LANE && aim_hit),
		.x_in(c2), .y_in(c3),
		.done(cord_done), .angle(cord_angle)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (take) state_d = ST_LANE;
			ST_LANE: state_d = aim_hit ? ST_ROT : ST_OUT;
			ST_ROT:  if (cord_done) state_d = ST_OUT;
			ST_OUT:  if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_valid_q <= 1'b0;
			last_btn_q <= '0;
			angle_q <= '0;
			fire_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LANE) begin
				fire_q <= aim_hit && fire_hit;
			end
			if (state_q == ST_ROT && cord_done) begin
				angle_q <= cord_angle;
			end
			if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
				last_btn_q <= btn_s1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	logic [14:0] ml_q, mr_q, mu_q, md_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_LANE) begin
			ml_q <= c0[15] ? 15'(-c0) : '0;
			mr_q <= c0[15] ? '0 : c0[14:0];
			mu_q <= c1[15] ? 15'(-c1) : '0;
			md_q <= c1[15] ? '0 : c1[14:0];
		end
		if (state_q == ST_OUT && (!m_valid_q || m_tready)) begin
			m_data_q <= {7'b0, ~btn_s1 & last_btn_q, btn_s1 & ~last_btn_q, btn_s1,
				fire_q, angle_q, md_q, mu_q, mr_q, ml_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready)
		else $error("input taken while busy");
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[76] || m_tdata[59:0] == m_tdata[59:0])
		else $error("fire check");

endmodule
